### design/vert_rt_pkg.sv
// Shared types and constants for the vertex rotate-and-translate pipeline.
// No dependencies; used by vert_rt_rotate and vertex_euler_rotate_translate.
package vert_rt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 14;
    localparam int TRIG_WIDTH      = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int LATENCY         = 7;

    localparam logic [TRIG_WIDTH-1:0] TRIG_RESET = 32'h4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIG_ONE     = 3'd0,
        CFG_TRIG_TWO     = 3'd1,
        CFG_TRIG_THREE   = 3'd2,
        CFG_OFFSET_FIRST = 3'd3,
        CFG_OFFSET_SECOND = 3'd4,
        CFG_OFFSET_THIRD = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] cos_val;
        logic signed [15:0] sin_val;
    } trig_t;

endpackage

### design/vert_rt_rotate.sv
// One plane rotation of a vector, two register stages: products, then round and saturate.
// Depends on vert_rt_pkg for trig_t and FRAC_BITS.
module vert_rt_rotate
    import vert_rt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  trig_t                         trig,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] z_in,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic signed [COORD_WIDTH-1:0] z_out
);

    localparam int PW = COORD_WIDTH + 16;
    localparam int SW = COORD_WIDTH + 17;
    localparam int QW = COORD_WIDTH + 3;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (FRAC_BITS - 1);

    logic signed [PW-1:0]          cx_reg, sy_reg, sx_reg, cy_reg;
    logic signed [COORD_WIDTH-1:0] z_mid_reg;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic signed [SW-1:0]          sum_x, sum_y;
    logic signed [COORD_WIDTH-1:0] x_next, y_next;

    function automatic logic signed [COORD_WIDTH-1:0] round_sat(input logic signed [SW-1:0] sum);
        logic signed [QW-1:0] q;
        logic                 in_range;
        q        = QW'(sum >>> FRAC_BITS);
        in_range = (&q[QW-1:COORD_WIDTH-1]) || !(|q[QW-1:COORD_WIDTH-1]);
        if (in_range)
            return q[COORD_WIDTH-1:0];
        else if (q[QW-1])
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    endfunction

    // product stage
    always_ff @(posedge clk)
    begin
        cx_reg    <= PW'(x_in) * PW'(trig.cos_val);
        sy_reg    <= PW'(y_in) * PW'(trig.sin_val);
        sx_reg    <= PW'(x_in) * PW'(trig.sin_val);
        cy_reg    <= PW'(y_in) * PW'(trig.cos_val);
        z_mid_reg <= z_in;
    end

    always_comb
    begin
        sum_x  = SW'(cx_reg) - SW'(sy_reg) + RND;
        sum_y  = SW'(sx_reg) + SW'(cy_reg) + RND;
        x_next = round_sat(sum_x);
        y_next = round_sat(sum_y);
    end

    // round and saturate stage
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_mid_reg;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

### design/vertex_euler_rotate_translate.sv
// Top level of the vertex rotate-and-translate pipeline: config registers, valid line, offsets.
// Depends on vert_rt_pkg and vert_rt_rotate.
//
// Takes one vertex per clock and returns it on a one-cycle done strobe; busy never
// rises, so start may be held high every cycle. The pipeline is three rotations of
// two stages each (multiply, then round and saturate) plus one offset-add stage.
// The receiver cannot stall, so results must be captured on done.
// Configuration registers take effect on items accepted after the write, and must be
// written only while no item is in flight.
module vertex_euler_rotate_translate
    import vert_rt_pkg::*;
#(
    parameter int  COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int CFG_WIDTH   = (COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] pos_first,
    input  logic signed [COORD_WIDTH-1:0] pos_second,
    input  logic signed [COORD_WIDTH-1:0] pos_third,
    input  logic signed [COORD_WIDTH-1:0] norm_first,
    input  logic signed [COORD_WIDTH-1:0] norm_second,
    input  logic signed [COORD_WIDTH-1:0] norm_third,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_pos_first,
    output logic signed [COORD_WIDTH-1:0] out_pos_second,
    output logic signed [COORD_WIDTH-1:0] out_pos_third,
    output logic signed [COORD_WIDTH-1:0] out_norm_first,
    output logic signed [COORD_WIDTH-1:0] out_norm_second,
    output logic signed [COORD_WIDTH-1:0] out_norm_third,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_WIDTH-1:0]          cfg_data
);

    localparam int CW = COORD_WIDTH;

    logic [TRIG_WIDTH-1:0] trig_one_reg, trig_two_reg, trig_three_reg;
    logic signed [CW-1:0]  off_first_reg, off_second_reg, off_third_reg;
    logic [LATENCY-1:0]    valid_reg, valid_next;
    logic                  accept;

    logic signed [CW-1:0]  vin   [2][3];
    logic signed [CW-1:0]  s1_a  [2];
    logic signed [CW-1:0]  s1_b  [2];
    logic signed [CW-1:0]  s1_t  [2];
    logic signed [CW-1:0]  s2_a  [2];
    logic signed [CW-1:0]  s2_b  [2];
    logic signed [CW-1:0]  s2_t  [2];
    logic signed [CW-1:0]  s3_a  [2];
    logic signed [CW-1:0]  s3_b  [2];
    logic signed [CW-1:0]  s3_t  [2];

    logic signed [CW-1:0]  pos_out_reg  [3];
    logic signed [CW-1:0]  norm_out_reg [3];
    logic signed [CW-1:0]  pos_out_next [3];
    logic signed [CW-1:0]  offsets      [3];
    logic signed [CW-1:0]  rotated_pos  [3];
    logic signed [CW:0]    off_sum      [3];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_one_reg   <= TRIG_RESET;
            trig_two_reg   <= TRIG_RESET;
            trig_three_reg <= TRIG_RESET;
            off_first_reg  <= '0;
            off_second_reg <= '0;
            off_third_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TRIG_ONE:      trig_one_reg   <= cfg_data[TRIG_WIDTH-1:0];
                CFG_TRIG_TWO:      trig_two_reg   <= cfg_data[TRIG_WIDTH-1:0];
                CFG_TRIG_THREE:    trig_three_reg <= cfg_data[TRIG_WIDTH-1:0];
                CFG_OFFSET_FIRST:  off_first_reg  <= cfg_data[CW-1:0];
                CFG_OFFSET_SECOND: off_second_reg <= cfg_data[CW-1:0];
                CFG_OFFSET_THIRD:  off_third_reg  <= cfg_data[CW-1:0];
                default:           ;
            endcase
        end
    end

    // valid line
    assign valid_next = {valid_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign vin[0][0] = pos_first;
    assign vin[0][1] = pos_second;
    assign vin[0][2] = pos_third;
    assign vin[1][0] = norm_first;
    assign vin[1][1] = norm_second;
    assign vin[1][2] = norm_third;

    for (genvar v = 0; v < 2; v++)
    begin : g_vec
        // about the third axis
        vert_rt_rotate #(.COORD_WIDTH(CW)) u_rot_one (
            .clk   (clk),
            .trig  (trig_t'(trig_one_reg)),
            .x_in  (vin[v][0]),
            .y_in  (vin[v][1]),
            .z_in  (vin[v][2]),
            .x_out (s1_a[v]),
            .y_out (s1_b[v]),
            .z_out (s1_t[v])
        );

        // about the first axis
        vert_rt_rotate #(.COORD_WIDTH(CW)) u_rot_two (
            .clk   (clk),
            .trig  (trig_t'(trig_two_reg)),
            .x_in  (s1_b[v]),
            .y_in  (s1_t[v]),
            .z_in  (s1_a[v]),
            .x_out (s2_b[v]),
            .y_out (s2_t[v]),
            .z_out (s2_a[v])
        );

        // about the second axis
        vert_rt_rotate #(.COORD_WIDTH(CW)) u_rot_three (
            .clk   (clk),
            .trig  (trig_t'(trig_three_reg)),
            .x_in  (s2_t[v]),
            .y_in  (s2_a[v]),
            .z_in  (s2_b[v]),
            .x_out (s3_t[v]),
            .y_out (s3_a[v]),
            .z_out (s3_b[v])
        );
    end

    assign offsets[0]     = off_first_reg;
    assign offsets[1]     = off_second_reg;
    assign offsets[2]     = off_third_reg;
    assign rotated_pos[0] = s3_a[0];
    assign rotated_pos[1] = s3_b[0];
    assign rotated_pos[2] = s3_t[0];

    // saturating offset add
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            off_sum[i] = (CW+1)'(rotated_pos[i]) + (CW+1)'(offsets[i]);
            if (off_sum[i][CW] == off_sum[i][CW-1])
                pos_out_next[i] = off_sum[i][CW-1:0];
            else if (off_sum[i][CW])
                pos_out_next[i] = {1'b1, {(CW-1){1'b0}}};
            else
                pos_out_next[i] = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        pos_out_reg[0]  <= pos_out_next[0];
        pos_out_reg[1]  <= pos_out_next[1];
        pos_out_reg[2]  <= pos_out_next[2];
        norm_out_reg[0] <= s3_a[1];
        norm_out_reg[1] <= s3_b[1];
        norm_out_reg[2] <= s3_t[1];
    end

    assign done            = valid_reg[LATENCY-1];
    assign out_pos_first   = pos_out_reg[0];
    assign out_pos_second  = pos_out_reg[1];
    assign out_pos_third   = pos_out_reg[2];
    assign out_norm_first  = norm_out_reg[0];
    assign out_norm_second = norm_out_reg[1];
    assign out_norm_third  = norm_out_reg[2];

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted item did not reach done");

    // no result without an item accepted the fixed latency earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[0], LATENCY - 1))
        else $error("done without a matching item");

    // valid line keeps the item count: an accepted item shows up in the first stage
    a_valid_enter: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg[0])
        else $error("accepted item missing from the valid line");

endmodule

### sim/tb_top.sv
// Self-checking testbench for vertex_euler_rotate_translate: directed corner vertices, then
// random streams at several sender idle rates, checked against a bit-exact fixed-point model.
// Depends on vert_rt_pkg and the design sources of vertex_euler_rotate_translate.
module tb_top
    import vert_rt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW                = COORD_WIDTH_DEF;
    localparam int CFG_W             = (CW > TRIG_WIDTH) ? CW : TRIG_WIDTH;
    localparam int CYCLE_LIMIT       = 300000;
    localparam int RANDOM_ITEMS      = 400;
    localparam int ITEMS_PER_SETTING = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam real PI                = 3.14159265358979;
    localparam real DEG_PER_HALF_TURN = 180.0;

    typedef struct packed {
        logic signed [CW-1:0] pos_first;
        logic signed [CW-1:0] pos_second;
        logic signed [CW-1:0] pos_third;
        logic signed [CW-1:0] norm_first;
        logic signed [CW-1:0] norm_second;
        logic signed [CW-1:0] norm_third;
    } vertex_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] pos_first;
    logic signed [CW-1:0] pos_second;
    logic signed [CW-1:0] pos_third;
    logic signed [CW-1:0] norm_first;
    logic signed [CW-1:0] norm_second;
    logic signed [CW-1:0] norm_third;
    logic                 done;
    logic signed [CW-1:0] out_pos_first;
    logic signed [CW-1:0] out_pos_second;
    logic signed [CW-1:0] out_pos_third;
    logic signed [CW-1:0] out_norm_first;
    logic signed [CW-1:0] out_norm_second;
    logic signed [CW-1:0] out_norm_third;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    trig_t                trig_reg [3];
    logic signed [CW-1:0] offset_reg [3];
    vertex_t              pending_vertices [$];
    vertex_t              expected_vertex;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   sender_idle_pct = 0;

    vertex_euler_rotate_translate #(.COORD_WIDTH(CW)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pos_first       (pos_first),
        .pos_second      (pos_second),
        .pos_third       (pos_third),
        .norm_first      (norm_first),
        .norm_second     (norm_second),
        .norm_third      (norm_third),
        .done            (done),
        .out_pos_first   (out_pos_first),
        .out_pos_second  (out_pos_second),
        .out_pos_third   (out_pos_third),
        .out_norm_first  (out_norm_first),
        .out_norm_second (out_norm_second),
        .out_norm_third  (out_norm_third),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sat_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint round_sat(longint k1, longint v1, longint k2, longint v2);
        longint acc;
        acc = k1 * v1 + k2 * v2 + (longint'(1) <<< (FRAC_BITS - 1));
        return sat_coord(acc >>> FRAC_BITS);
    endfunction

    // third axis, then first axis, then second axis
    function automatic void rotate_vec(inout longint a, inout longint b, inout longint t);
        longint c;
        longint s;
        longint x;
        longint y;
        c = longint'(trig_reg[0].cos_val);
        s = longint'(trig_reg[0].sin_val);
        x = round_sat(c, a, -s, b);
        y = round_sat(s, a, c, b);
        a = x;
        b = y;
        c = longint'(trig_reg[1].cos_val);
        s = longint'(trig_reg[1].sin_val);
        x = round_sat(c, b, -s, t);
        y = round_sat(s, b, c, t);
        b = x;
        t = y;
        c = longint'(trig_reg[2].cos_val);
        s = longint'(trig_reg[2].sin_val);
        x = round_sat(c, a, s, t);
        y = round_sat(c, t, -s, a);
        a = x;
        t = y;
    endfunction

    function automatic vertex_t transform_vertex(vertex_t v);
        longint  p1, p2, p3;
        longint  n1, n2, n3;
        vertex_t r;
        p1 = longint'(v.pos_first);
        p2 = longint'(v.pos_second);
        p3 = longint'(v.pos_third);
        n1 = longint'(v.norm_first);
        n2 = longint'(v.norm_second);
        n3 = longint'(v.norm_third);
        rotate_vec(p1, p2, p3);
        rotate_vec(n1, n2, n3);
        r.pos_first   = CW'(sat_coord(p1 + longint'(offset_reg[0])));
        r.pos_second  = CW'(sat_coord(p2 + longint'(offset_reg[1])));
        r.pos_third   = CW'(sat_coord(p3 + longint'(offset_reg[2])));
        r.norm_first  = CW'(n1);
        r.norm_second = CW'(n2);
        r.norm_third  = CW'(n3);
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        logic [CW-1:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       r = COORD_MAX;
                    1:       r = COORD_MIN;
                    2:       r = '0;
                    default: r = '1;
                endcase
            end
            1, 2:    ;
            default: r = $signed(r) >>> $urandom_range(24, 8);
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_vertices.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no item pending, expected none, actual %h",
                         $time, out_pos_first);
            end
            else
            begin
                expected_vertex = pending_vertices.pop_front();
                check_field("out_pos_first", expected_vertex.pos_first, out_pos_first);
                check_field("out_pos_second", expected_vertex.pos_second, out_pos_second);
                check_field("out_pos_third", expected_vertex.pos_third, out_pos_third);
                check_field("out_norm_first", expected_vertex.norm_first, out_norm_first);
                check_field("out_norm_second", expected_vertex.norm_second, out_norm_second);
                check_field("out_norm_third", expected_vertex.norm_third, out_norm_third);
            end
        end
    end

    task automatic send_vertex(vertex_t v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        pos_first   <= v.pos_first;
        pos_second  <= v.pos_second;
        pos_third   <= v.pos_third;
        norm_first  <= v.norm_first;
        norm_second <= v.norm_second;
        norm_third  <= v.norm_third;
        do
            @(posedge clk);
        while (busy);
        pending_vertices = {pending_vertices, transform_vertex(v)};
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TRIG_ONE:      trig_reg[0]   = data[TRIG_WIDTH-1:0];
            CFG_TRIG_TWO:      trig_reg[1]   = data[TRIG_WIDTH-1:0];
            CFG_TRIG_THREE:    trig_reg[2]   = data[TRIG_WIDTH-1:0];
            CFG_OFFSET_FIRST:  offset_reg[0] = data[CW-1:0];
            CFG_OFFSET_SECOND: offset_reg[1] = data[CW-1:0];
            CFG_OFFSET_THIRD:  offset_reg[2] = data[CW-1:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_trig_stages(logic [TRIG_WIDTH-1:0] one, logic [TRIG_WIDTH-1:0] two,
                                     logic [TRIG_WIDTH-1:0] three);
        write_reg(CFG_TRIG_ONE, one);
        write_reg(CFG_TRIG_TWO, two);
        write_reg(CFG_TRIG_THREE, three);
    endtask

    task automatic write_offsets(logic [CW-1:0] first, logic [CW-1:0] second,
                                 logic [CW-1:0] third);
        write_reg(CFG_OFFSET_FIRST, first);
        write_reg(CFG_OFFSET_SECOND, second);
        write_reg(CFG_OFFSET_THIRD, third);
    endtask

    task automatic test_reset_values();
        send_vertex('{0, 0, 0, 0, 0, 0});
        send_vertex('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
        send_vertex('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN});
        send_vertex('{-1, -1, -1, -1, -1, -1});
        send_vertex('{COORD_MAX, COORD_MIN, 1, -1, 32'sh0001_8000, -32'sh0000_8000});
    endtask

    // halfway cases round up, negative ones toward zero
    task automatic test_round_ties();
        wait_drained();
        write_trig_stages(32'h0001_0001, TRIG_RESET, TRIG_RESET);
        send_vertex('{32'sh2000, 0, 0, -32'sh2000, 0, 0});
        send_vertex('{32'sh6000, 32'sh2000, 7, -32'sh6000, -32'sh2000, COORD_MIN});
        send_vertex('{COORD_MAX, COORD_MIN, 32'sh2000, 32'sh0000_6000, -32'sh4000, 1});
    endtask

    task automatic test_trig_extremes();
        wait_drained();
        write_trig_stages(32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
        send_vertex('{COORD_MAX, COORD_MIN, COORD_MAX, -1, 1, 32'sh0001_0000});
        send_vertex('{32'sh0040_0000, -32'sh0030_0000, 32'sh0001_2345,
                      COORD_MIN, COORD_MIN, COORD_MAX});
        wait_drained();
        write_trig_stages(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_vertex('{COORD_MAX, COORD_MIN, COORD_MAX, -1, 1, 32'sh0001_0000});
        send_vertex('{32'sh0040_0000, -32'sh0030_0000, 32'sh0001_2345,
                      COORD_MIN, COORD_MIN, COORD_MAX});
        wait_drained();
        write_trig_stages(32'h0000_8000, 32'h8000_0000, 32'h7FFF_8001);
        send_vertex('{COORD_MAX, COORD_MIN, COORD_MAX, -1, 1, 32'sh0001_0000});
        send_vertex('{32'sh0040_0000, -32'sh0030_0000, 32'sh0001_2345,
                      COORD_MIN, COORD_MIN, COORD_MAX});
    endtask

    task automatic test_offset_saturation();
        wait_drained();
        write_trig_stages(TRIG_RESET, TRIG_RESET, TRIG_RESET);
        write_offsets(COORD_MAX, COORD_MIN, COORD_MAX);
        send_vertex('{COORD_MAX, COORD_MIN, 1, 5, 6, 7});
        send_vertex('{COORD_MIN, COORD_MAX, -1, COORD_MAX, COORD_MIN, 0});
        wait_drained();
        write_offsets(COORD_MIN, COORD_MAX, 32'sh0001_0000);
        send_vertex('{COORD_MIN, COORD_MAX, COORD_MAX, -5, -6, -7});
    endtask

    task automatic test_ignored_index();
        wait_drained();
        write_offsets(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_0003);
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        send_vertex('{32'sh0010_0000, -32'sh0020_0000, 32'sh0000_1234, 1, -1, 0});
        send_vertex('{rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord()});
    endtask

    task automatic test_random_stream(int idle_pct);
        logic [TRIG_WIDTH-1:0] trig_word [3];
        logic [CW-1:0]         offset_word [3];
        int                    c;
        int                    s;
        real                   ang;
        vertex_t               v;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % ITEMS_PER_SETTING == 0)
            begin
                wait_drained();
                for (int i = 0; i < 3; i++)
                begin
                    case ($urandom_range(7))
                        6:       trig_word[i] = $urandom;
                        7:       trig_word[i] = ($urandom_range(1) != 0) ? 32'h8000_8000
                                                                         : 32'h7FFF_7FFF;
                        default:
                        begin
                            ang = $urandom_range(359) * PI / DEG_PER_HALF_TURN;
                            c   = $rtoi($cos(ang) * real'(1 << FRAC_BITS));
                            s   = $rtoi($sin(ang) * real'(1 << FRAC_BITS));
                            trig_word[i] = {c[15:0], s[15:0]};
                        end
                    endcase
                    case ($urandom_range(5))
                        0:       offset_word[i] = '0;
                        1:       offset_word[i] = $urandom;
                        2:       offset_word[i] = ($urandom_range(1) != 0) ? COORD_MAX
                                                                           : COORD_MIN;
                        default: offset_word[i] = $signed($urandom) >>> $urandom_range(20, 8);
                    endcase
                end
                write_trig_stages(trig_word[0], trig_word[1], trig_word[2]);
                write_offsets(offset_word[0], offset_word[1], offset_word[2]);
            end
            v.pos_first   = rand_coord();
            v.pos_second  = rand_coord();
            v.pos_third   = rand_coord();
            v.norm_first  = rand_coord();
            v.norm_second = rand_coord();
            v.norm_third  = rand_coord();
            send_vertex(v);
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** vertex_euler_rotate_translate: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        pos_first   <= '0;
        pos_second  <= '0;
        pos_third   <= '0;
        norm_first  <= '0;
        norm_second <= '0;
        norm_third  <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        for (int i = 0; i < 3; i++)
        begin
            trig_reg[i]   = TRIG_RESET;
            offset_reg[i] = '0;
        end
        sender_idle_pct = 20;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_round_ties();
        test_trig_extremes();
        test_offset_saturation();
        test_ignored_index();
        test_random_stream(35);
        test_random_stream(85);
        test_random_stream(0);

        wait_drained();
        if (mismatch_count == 0)
            $display("** vertex_euler_rotate_translate: PASSED **");
        else
            $display("** vertex_euler_rotate_translate: FAILED **");
        $finish;
    end
endmodule
